[hw/rtl/tbf_pkg.sv]
// Shared types and codes for the three-reader broadcast FIFO.
package tbf_pkg;

    localparam int DATA_W   = 32;
    localparam int THR_W    = 4;
    localparam int MARK_W   = 3;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [THR_W-1:0] THR_RESET = 4'd3;

    // Register index carried in paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_FEW  = 2'd2;
    localparam logic [1:0] ST_SEEN = 2'd3;

    localparam logic [MARK_W-1:0] MARKS_ALL = 3'b111;

    typedef struct packed {
        logic               cmd;
        logic [1:0]         reader_id;
        logic signed [31:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_data;
        logic               head_removed;
    } out_item_t;

endpackage

[hw/rtl/three_reader_broadcast_fifo.sv]
// Three-reader broadcast FIFO top level: register port, control and store.
// Results are registered: valid in the cycle after the request is accepted.
// Throughput: one request per cycle unless an untaken result stalls; the head value
// is prefetched from the store's registered read port so each read completes
// in a single pass. Reset: pointers, occupancy, read marks and output valid
// clear at once and the threshold returns to 3; store contents are not cleared.
module three_reader_broadcast_fifo
    import tbf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [THR_W-1:0]  thr_reg, thr_next;
    logic              cfg_wr;
    logic              st_wr_en;
    logic [PTR_W-1:0]  st_wr_addr;
    logic [DATA_W-1:0] st_wr_data;
    logic [PTR_W-1:0]  st_rd_addr;
    logic [DATA_W-1:0] st_rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_wr && (paddr[2] == REG_THRESHOLD))
        begin
            thr_next = pwdata[THR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign prdata = (paddr[2] == REG_THRESHOLD) ? APB_DW'(thr_reg) : '0;

    tbf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .threshold  (thr_reg),
        .st_wr_en   (st_wr_en),
        .st_wr_addr (st_wr_addr),
        .st_wr_data (st_wr_data),
        .st_rd_addr (st_rd_addr),
        .st_rd_data (st_rd_data)
    );

    tbf_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted request produced no result");

    a_pop_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.head_removed) |-> (out_item.status == ST_DONE))
        else $error("head removed on a refused request");

    a_refusal_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status != ST_DONE)) |->
            ((out_item.read_data == '0) && !out_item.head_removed))
        else $error("refused request carries data");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

[hw/rtl/tbf_store.sv]
// Entry store: one write port, head prefetch read port with registered data.
module tbf_store
    import tbf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [DATA_W-1:0]          wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Forward a write that lands on the entry being fetched
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/tbf_ctrl.sv]
// Request decode, pointer, occupancy and read-mark control with result register.
module tbf_ctrl
    import tbf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  in_item_t                   in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output out_item_t                  out_item,
    input  logic [THR_W-1:0]           threshold,
    output logic                       st_wr_en,
    output logic [$clog2(DEPTH)-1:0]   st_wr_addr,
    output logic [DATA_W-1:0]          st_wr_data,
    output logic [$clog2(DEPTH)-1:0]   st_rd_addr,
    input  logic [DATA_W-1:0]          st_rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MARK_W-1:0] marks_reg, marks_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic              fire;
    logic [MARK_W-1:0] reader_bit;
    logic [MARK_W-1:0] marks_set;
    logic              full;
    logic              readable;
    logic              do_write;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        case (in_item.reader_id)
            2'd0:    reader_bit = 3'b001;
            2'd1:    reader_bit = 3'b010;
            2'd2:    reader_bit = 3'b100;
            default: reader_bit = 3'b000;
        endcase
    end

    assign full      = (count_reg == CNT_FULL);
    assign readable  = CMP_W'(count_reg) > CMP_W'(threshold);
    assign marks_set = marks_reg | reader_bit;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        marks_next     = marks_reg;
        do_write       = 1'b0;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (fire)
        begin
            out_valid_next             = 1'b1;
            out_item_next.status       = ST_DONE;
            out_item_next.read_data    = '0;
            out_item_next.head_removed = 1'b0;

            if (in_item.cmd == CMD_WRITE)
            begin
                if (full)
                begin
                    out_item_next.status = ST_FULL;
                end
                else
                begin
                    do_write   = 1'b1;
                    tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                // Mark test first, then occupancy against the threshold
                if ((reader_bit == '0) || ((marks_reg & reader_bit) != '0))
                begin
                    out_item_next.status = ST_SEEN;
                end
                else if (!readable)
                begin
                    out_item_next.status = ST_FEW;
                end
                else
                begin
                    out_item_next.read_data = st_rd_data;
                    if (marks_set == MARKS_ALL)
                    begin
                        head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                        count_next = count_next - 1'b1;
                        marks_next = '0;
                        out_item_next.head_removed = 1'b1;
                    end
                    else
                    begin
                        marks_next = marks_set;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            marks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            marks_reg     <= marks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign st_wr_en   = do_write;
    assign st_wr_addr = tail_reg;
    assign st_wr_data = in_item.write_value;
    // Fetch the head that will hold after this edge
    assign st_rd_addr = head_next;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
